// ===== hw/rtl/gmig_pkg.sv =====
// Shared types and constants of the grid mesh index generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package gmig_pkg;

	localparam int VI_W   = 20;  // width of an emitted vertex index
	localparam int CFG_W  = 11;  // width of the size registers
	localparam int CIDX_W = 2;   // width of the register index

	typedef logic [CIDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_GRID_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_GRID_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_SOLID_MODE  = 2'd2;

	localparam logic [CFG_W-1:0] SIDE_RESET = 11'd2;

	// walk phase codes
	localparam logic [1:0] PH_DONE  = 2'd0;
	localparam logic [1:0] PH_ROWS  = 2'd1;
	localparam logic [1:0] PH_COLS  = 2'd2;
	localparam logic [1:0] PH_SOLID = 2'd3;

	// solid strip substeps
	localparam logic [1:0] SS_TOP   = 2'd0;
	localparam logic [1:0] SS_BOT   = 2'd1;
	localparam logic [1:0] SS_JOINA = 2'd2;
	localparam logic [1:0] SS_JOINB = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] grid_width;
		logic [CFG_W-1:0] grid_height;
		logic             solid_mode;
	} cfg_regs_t;

	typedef struct packed {
		logic [VI_W-1:0] vertex_index;
		logic            index_valid;
		logic            last_index;
	} beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gmig_walk.sv =====
// Walk state and single-step next-index logic of the grid mesh index generator.
// Depends on gmig_pkg for the configuration and result beat types.
`default_nettype none

module gmig_walk #(
	parameter int MAX_SIDE = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              restart,
	input  wire gmig_pkg::cfg_regs_t cfg,
	output gmig_pkg::beat_t        emit
);
	import gmig_pkg::*;

	localparam int CNT_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);

	logic [1:0]        phase_q;
	logic [CNT_W-1:0]  row_q, col_q;
	logic              dir_q;
	logic [1:0]        sub_q;
	logic [SIDE_W-1:0] lat_w_q, lat_h_q;
	logic [VI_W-1:0]   base_q, base_nx_q;  // row*w and (row+1)*w, modulo 2^20

	logic [1:0]        e_phase, n_phase;
	logic [CNT_W-1:0]  e_row, e_col, n_row, n_col;
	logic              e_dir, n_dir;
	logic [1:0]        e_sub, n_sub;
	logic [SIDE_W-1:0] e_w, e_h, w1, h1;
	logic [VI_W-1:0]   e_base, e_base_nx, n_base, n_base_nx;
	logic [VI_W-1:0]   w_ext, sel_base, sel_col;
	logic              last;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [31:0] c;
		c = 32'(v);
		if (c < 32'd2)
			c = 32'd2;
		else if (c > 32'(MAX_SIDE))
			c = 32'(MAX_SIDE);
		return SIDE_W'(c);
	endfunction

	always_comb begin
		// a restart beat starts a fresh walk and already emits its first index
		if (restart) begin
			e_w       = clamp_side(cfg.grid_width);
			e_h       = clamp_side(cfg.grid_height);
			e_phase   = cfg.solid_mode ? PH_SOLID : PH_ROWS;
			e_row     = '0;
			e_col     = '0;
			e_dir     = 1'b0;
			e_sub     = SS_TOP;
			e_base    = '0;
			e_base_nx = VI_W'(e_w);
		end else begin
			e_w       = lat_w_q;
			e_h       = lat_h_q;
			e_phase   = phase_q;
			e_row     = row_q;
			e_col     = col_q;
			e_dir     = dir_q;
			e_sub     = sub_q;
			e_base    = base_q;
			e_base_nx = base_nx_q;
		end

		w1    = e_w - SIDE_W'(1);
		h1    = e_h - SIDE_W'(1);
		w_ext = VI_W'(e_w);

		n_phase   = e_phase;
		n_row     = e_row;
		n_col     = e_col;
		n_dir     = e_dir;
		n_sub     = e_sub;
		n_base    = e_base;
		n_base_nx = e_base_nx;
		sel_base  = e_base;
		sel_col   = VI_W'(e_col);
		last      = 1'b0;

		case (e_phase)
			PH_ROWS: begin
				if (!e_dir && SIDE_W'(e_col) < w1) begin
					n_col = e_col + CNT_W'(1);
				end else if (e_dir && e_col != '0) begin
					n_col = e_col - CNT_W'(1);
				end else if (SIDE_W'(e_row) < h1) begin
					n_row     = e_row + CNT_W'(1);
					n_base    = e_base_nx;
					n_base_nx = e_base_nx + w_ext;
					n_dir     = ~e_dir;
				end else begin
					n_phase = PH_COLS;
					n_dir   = 1'b1;
				end
			end
			PH_COLS: begin
				if (e_dir && e_row != '0) begin
					n_row     = e_row - CNT_W'(1);
					n_base    = e_base - w_ext;
					n_base_nx = e_base;
				end else if (!e_dir && SIDE_W'(e_row) < h1) begin
					n_row     = e_row + CNT_W'(1);
					n_base    = e_base_nx;
					n_base_nx = e_base_nx + w_ext;
				end else if (!e_h[0] ? (SIDE_W'(e_col) >= w1) : (e_col == '0)) begin
					n_phase = PH_DONE;
					last    = 1'b1;
				end else begin
					n_col = !e_h[0] ? e_col + CNT_W'(1) : e_col - CNT_W'(1);
					n_dir = ~e_dir;
				end
			end
			PH_SOLID: begin
				case (e_sub)
					SS_TOP: begin
						n_sub = SS_BOT;
					end
					SS_BOT: begin
						sel_base = e_base_nx;
						if (SIDE_W'(e_col) < w1) begin
							n_col = e_col + CNT_W'(1);
							n_sub = SS_TOP;
						end else if (SIDE_W'(e_row) + SIDE_W'(1) < h1) begin
							n_sub = SS_JOINA;
						end else begin
							n_phase = PH_DONE;
							last    = 1'b1;
						end
					end
					SS_JOINA: begin
						sel_base = e_base_nx;
						sel_col  = VI_W'(w1);
						n_sub    = SS_JOINB;
					end
					default: begin
						sel_base  = e_base_nx;
						sel_col   = '0;
						n_row     = e_row + CNT_W'(1);
						n_col     = '0;
						n_base    = e_base_nx;
						n_base_nx = e_base_nx + w_ext;
						n_sub     = SS_TOP;
					end
				endcase
			end
			default: begin
				sel_base = '0;
				sel_col  = '0;
			end
		endcase

		emit.vertex_index = sel_base + sel_col;
		emit.index_valid  = (e_phase != PH_DONE);
		emit.last_index   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DONE;
			row_q     <= '0;
			col_q     <= '0;
			dir_q     <= 1'b0;
			sub_q     <= SS_TOP;
			lat_w_q   <= SIDE_W'(2);
			lat_h_q   <= SIDE_W'(2);
			base_q    <= '0;
			base_nx_q <= VI_W'(2);
		end else if (step) begin
			phase_q   <= n_phase;
			row_q     <= n_row;
			col_q     <= n_col;
			dir_q     <= n_dir;
			sub_q     <= n_sub;
			lat_w_q   <= e_w;
			lat_h_q   <= e_h;
			base_q    <= n_base;
			base_nx_q <= n_base_nx;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_mesh_index_generator.sv =====
// Grid mesh index generator: top level with configuration registers and
// the output register. Depends on gmig_pkg and gmig_walk.
//
// Usage:
//   Each input beat is one request. restart=1 latches grid_width, grid_height
//   (saturated to 2..MAX_SIDE) and solid_mode and emits the first index of a
//   new walk; restart=0 emits the next index. Every input beat yields exactly
//   one output beat: vertex_index, index_valid, last_index. Once the walk has
//   ended, beats come back with index_valid=0 until the next restart.
//   Wireframe walks give 2*w*h indices, solid walks 2*w*(h-1)+2*(h-2).
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wr_data) take effect at
//   the next restart; write them while no beats are in flight.
//   Output: an accepted input beat is registered and shows at the output in the next cycle.
//   Throughput: one beat per cycle while in_stall is low; the walk step is one pass of counter
//   logic plus one 20-bit add, with row base addresses kept incrementally.
//   Stall: in_stall is raised only while the output register holds a beat
//   that the receiver stalls; the output payload then holds.
//   Reset: no walk active, sizes 2 by 2, wireframe mode, output register empty.
`default_nettype none

module grid_mesh_index_generator #(
	parameter int MAX_SIDE = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire gmig_pkg::cfg_idx_t               cfg_index,
	input  wire logic [gmig_pkg::CFG_W-1:0]       cfg_wr_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             restart,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [gmig_pkg::VI_W-1:0]             vertex_index,
	output logic                                  index_valid,
	output logic                                  last_index
);
	import gmig_pkg::*;

	cfg_regs_t cfg_q;
	beat_t     emit;
	beat_t     beat_q;
	logic      out_valid_q;
	logic      in_acc;

	// Hold the input only while a finished beat sits stalled in the output register.
	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= SIDE_RESET;
			cfg_q.grid_height <= SIDE_RESET;
			cfg_q.solid_mode  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_wr_data;
				CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_wr_data;
				CFG_SOLID_MODE:  cfg_q.solid_mode  <= cfg_wr_data[0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	gmig_walk #(
		.MAX_SIDE(MAX_SIDE)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_acc),
		.restart(restart),
		.cfg    (cfg_q),
		.emit   (emit)
	);

	// Output register: load on every accepted request, empty when drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			beat_q <= emit;
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = beat_q.vertex_index;
	assign index_valid  = beat_q.index_valid;
	assign last_index   = beat_q.last_index;

endmodule

`default_nettype wire

// ===== hw/rtl/gmig_checker.sv =====
// Port-level checks for the grid mesh index generator, bound to its top level.
// Depends on gmig_pkg for the port types.
`default_nettype none

module gmig_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cfg_wr_en,
	input wire gmig_pkg::cfg_idx_t         cfg_index,
	input wire logic [gmig_pkg::CFG_W-1:0] cfg_wr_data,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       restart,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [gmig_pkg::VI_W-1:0]  vertex_index,
	input wire logic                       index_valid,
	input wire logic                       last_index
);
	import gmig_pkg::*;

	// a stalled beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_index)
			&& $stable(index_valid) && $stable(last_index))
		else $error("stalled output beat changed");

	// input stall only ever comes from a full, stalled output register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output beat");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_index |-> index_valid)
		else $error("last flag on an invalid index");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !index_valid |-> vertex_index == '0 && !last_index)
		else $error("ended walk returned a nonzero beat");

	// a restart always opens with vertex 0, never the last one
	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && restart |=> out_valid && index_valid
			&& vertex_index == '0 && !last_index)
		else $error("restart did not emit the first vertex");

endmodule

bind grid_mesh_index_generator gmig_checker u_gmig_checker (.*);

`default_nettype wire
